// ----- design/bqd_pkg.sv -----
package bqd_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // wide sum wraps modulo 2^64, rounding drops 20 bits, output scale is UQ1.30
    localparam int ACC_W    = 64;
    localparam int RND_SH   = 20;
    localparam int SCALE_SH = 30;
    localparam int Q_W      = ACC_W - RND_SH - SCALE_SH;
    localparam int R_W      = SCALE_SH;

    localparam int MAC_STEPS = 5;

    localparam int CFG_ADDR_W = 3;

    localparam longint FF_COEF0_RESET     = 64'd4194304;
    localparam longint OUTPUT_SCALE_RESET = 64'd268435456;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FF_COEF0     = 3'd0,
        REG_FF_COEF1     = 3'd1,
        REG_FF_COEF2     = 3'd2,
        REG_FB_COEF1     = 3'd3,
        REG_FB_COEF2     = 3'd4,
        REG_OUTPUT_SCALE = 3'd5
    } cfg_reg_t;

    // operand pair for the shared multiplier; the first five follow the mac order
    typedef enum logic [2:0] {
        SEL_X0    = 3'd0,
        SEL_X1    = 3'd1,
        SEL_X2    = 3'd2,
        SEL_Y1    = 3'd3,
        SEL_Y2    = 3'd4,
        SEL_FRAC  = 3'd5,
        SEL_WHOLE = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_add;
        logic     rnd_ld;
        logic     frac_ld;
        logic     fin;
    } bqd_ctrl_t;

endpackage

// ----- design/bqd_seq.sv -----
module bqd_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_free,
    output logic                in_ready,
    output bqd_pkg::bqd_ctrl_t  ctrl
);
    import bqd_pkg::*;

    localparam int CNT_W = $clog2(MAC_STEPS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_RND   = 6'b000100,
        ST_FRAC  = 6'b001000,
        ST_WHOLE = 6'b010000,
        ST_SAT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ctrl         = '0;
        ctrl.mul_sel = SEL_X0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC: begin
                // product issued last cycle is added while the next one is formed
                ctrl.acc_add = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(MAC_STEPS)) begin
                    state_next = ST_RND;
                end else begin
                    ctrl.mul_en  = 1'b1;
                    ctrl.mul_sel = mul_sel_t'(3'(cnt_reg));
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_RND: begin
                ctrl.rnd_ld = 1'b1;
                state_next  = ST_FRAC;
            end
            ST_FRAC: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = SEL_FRAC;
                state_next   = ST_WHOLE;
            end
            ST_WHOLE: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = SEL_WHOLE;
                ctrl.frac_ld = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT: begin
                if (out_free) begin
                    ctrl.fin   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ----- design/bqd_dp.sv -----
module bqd_dp #(
    parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bqd_pkg::bqd_ctrl_t            ctrl,
    input  logic                          in_fire,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [COEF_BITS-1:0]   ff_coef0,
    input  logic signed [COEF_BITS-1:0]   ff_coef1,
    input  logic signed [COEF_BITS-1:0]   ff_coef2,
    input  logic signed [COEF_BITS-1:0]   fb_coef1,
    input  logic signed [COEF_BITS-1:0]   fb_coef2,
    input  logic        [COEF_BITS-2:0]   output_scale,
    output logic signed [SAMPLE_BITS-1:0] sample_sat,
    output logic                          clip
);
    import bqd_pkg::*;

    localparam int MA  = COEF_BITS + 1;
    localparam int MB  = (SAMPLE_BITS > R_W) ? SAMPLE_BITS : R_W + 1;
    localparam int PW  = MA + MB;
    localparam int F_W = PW + 1 - SCALE_SH;

    logic signed [SAMPLE_BITS-1:0] x_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic        [ACC_W-1:0]       acc_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [Q_W-1:0]         q_reg;
    logic        [R_W-1:0]         r_reg;
    logic        [F_W-1:0]         frac_reg;

    logic signed [MA-1:0] a_op;
    logic signed [MB-1:0] b_op;
    logic        [ACC_W-1:0] rsum;
    logic        [PW:0]   fsum;
    logic signed [PW:0]   psum;
    logic                 pos_clip, neg_clip;

    always_comb begin
        unique case (ctrl.mul_sel)
            SEL_X0:    begin a_op = MA'(ff_coef0); b_op = MB'(x_reg);  end
            SEL_X1:    begin a_op = MA'(ff_coef1); b_op = MB'(x1_reg); end
            SEL_X2:    begin a_op = MA'(ff_coef2); b_op = MB'(x2_reg); end
            SEL_Y1:    begin a_op = MA'(fb_coef1); b_op = MB'(y1_reg); end
            SEL_Y2:    begin a_op = MA'(fb_coef2); b_op = MB'(y2_reg); end
            SEL_FRAC:  begin a_op = MA'(output_scale); b_op = MB'(r_reg); end
            SEL_WHOLE: begin a_op = MA'(output_scale); b_op = MB'(q_reg); end
            default:   begin a_op = '0; b_op = '0; end
        endcase
    end

    // round half up by 20 bits, then split into whole part and 30-bit remainder
    assign rsum = acc_reg + (ACC_W'(1) << (RND_SH - 1));
    // remainder product is never negative
    assign fsum = {1'b0, prod_reg} + ((PW + 1)'(1) << (SCALE_SH - 1));
    assign psum = {prod_reg[PW-1], prod_reg} + {{SCALE_SH{1'b0}}, frac_reg};

    assign pos_clip = !psum[PW] && (|psum[PW-1:SAMPLE_BITS-1]);
    assign neg_clip = psum[PW] && !(&psum[PW-1:SAMPLE_BITS-1]);
    assign clip     = pos_clip || neg_clip;

    always_comb begin
        if (pos_clip) begin
            sample_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (neg_clip) begin
            sample_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            sample_sat = psum[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x_reg   <= sample_in;
            acc_reg <= '0;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.mul_en) begin
            prod_reg <= a_op * b_op;
        end
        if (ctrl.rnd_ld) begin
            q_reg <= rsum[ACC_W-1 -: Q_W];
            r_reg <= rsum[RND_SH +: R_W];
        end
        if (ctrl.frac_ld) begin
            frac_reg <= fsum[PW:SCALE_SH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (ctrl.fin) begin
            x1_reg <= x_reg;
            x2_reg <= x1_reg;
            y1_reg <= sample_sat;
            y2_reg <= y1_reg;
        end
    end

endmodule

// ----- design/peaking_biquad_df1_filter.sv -----
// Direct Form I peaking biquad on signed audio samples. One sample is taken per
// s_ transfer and one result leaves per m_ transfer; a sample occupies the block
// from its transfer until its result is registered, and no new sample is taken
// before then, because a single multiplier is reused seven times under a small
// sequencer: five coefficient products accumulated into a 64-bit sum, then two
// products that apply the UQ1.30 output scale. s_tready is low while a sample is
// in work. The result sits in an output register, so the next sample may be taken
// while it waits for m_tready; if that register is still held when the next
// result is ready, the sequencer waits in its last step until it is free.
// Coefficients are Q12.20; the user must write them through cfg_wr_en, cfg_addr
// and cfg_wdata only while the block is idle, which the block itself does not
// enforce; reset values pass the input straight through. m_tuser[0] flags a
// result that was saturated.
module peaking_biquad_df1_filter #(
    parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // sample_out
    output logic [0:0]                           m_tuser,  // clipped
    input  logic                                 cfg_wr_en,
    input  logic [bqd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [COEF_BITS-1:0]                 cfg_wdata
);
    import bqd_pkg::*;

    localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic signed [COEF_BITS-1:0] ff_coef0_reg, ff_coef1_reg, ff_coef2_reg;
    logic signed [COEF_BITS-1:0] fb_coef1_reg, fb_coef2_reg;
    logic        [COEF_BITS-2:0] output_scale_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_clip_reg;

    bqd_ctrl_t                     ctrl;
    logic                          in_ready, in_fire, out_free;
    logic signed [SAMPLE_BITS-1:0] sample_sat;
    logic                          clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_coef0_reg     <= COEF_BITS'(FF_COEF0_RESET);
            ff_coef1_reg     <= '0;
            ff_coef2_reg     <= '0;
            fb_coef1_reg     <= '0;
            fb_coef2_reg     <= '0;
            output_scale_reg <= (COEF_BITS - 1)'(OUTPUT_SCALE_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FF_COEF0:     ff_coef0_reg     <= cfg_wdata;
                REG_FF_COEF1:     ff_coef1_reg     <= cfg_wdata;
                REG_FF_COEF2:     ff_coef2_reg     <= cfg_wdata;
                REG_FB_COEF1:     fb_coef1_reg     <= cfg_wdata;
                REG_FB_COEF2:     fb_coef2_reg     <= cfg_wdata;
                REG_OUTPUT_SCALE: output_scale_reg <= cfg_wdata[COEF_BITS-2:0];
                default: ;
            endcase
        end
    end

    assign in_fire  = s_tvalid && in_ready;
    assign out_free = !out_valid_reg || m_tready;

    bqd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    bqd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .in_fire      (in_fire),
        .sample_in    (s_tdata[SAMPLE_BITS-1:0]),
        .ff_coef0     (ff_coef0_reg),
        .ff_coef1     (ff_coef1_reg),
        .ff_coef2     (ff_coef2_reg),
        .fb_coef1     (fb_coef1_reg),
        .fb_coef2     (fb_coef2_reg),
        .output_scale (output_scale_reg),
        .sample_sat   (sample_sat),
        .clip         (clip)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fin) begin
            out_sample_reg <= sample_sat;
            out_clip_reg   <= clip;
        end
    end

    assign s_tready   = in_ready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = TD_W'(unsigned'(out_sample_reg));
    assign m_tuser[0] = out_clip_reg;

    // a result is only committed into a free output register
    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fin |-> (!m_tvalid || m_tready))
        else $error("result committed over a pending transfer");

    // nothing is in the multiplier while a new sample can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ctrl.mul_en && !ctrl.acc_add && !ctrl.fin)
        else $error("datapath active while ready");

    // a clipped result holds one of the two range limits
    a_clip_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ((!m_tdata[SAMPLE_BITS-1] && (&m_tdata[SAMPLE_BITS-2:0])) ||
             (m_tdata[SAMPLE_BITS-1] && !(|m_tdata[SAMPLE_BITS-2:0]))))
        else $error("clipped result not at a range limit");

endmodule
